@@ rtl/tgnm_pkg.sv @@
// ============================================================================
// tgnm_pkg
// Shared types, constants and register indexes for the touch grid note mapper.
// ============================================================================
package tgnm_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;

    localparam logic [2:0] REG_PANEL_WIDTH  = 3'd0;
    localparam logic [2:0] REG_PANEL_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FULL_PRESS   = 3'd2;
    localparam logic [2:0] REG_ROW_COUNT    = 3'd3;
    localparam logic [2:0] REG_SEMI_ACROSS  = 3'd4;
    localparam logic [2:0] REG_BASE_NOTE    = 3'd5;

    localparam logic [1:0] CMD_ON    = 2'd0;
    localparam logic [1:0] CMD_CONT  = 2'd1;
    localparam logic [1:0] CMD_OFF   = 2'd2;
    localparam logic [1:0] CMD_WRITE = 2'd3;

    localparam logic signed [15:0] STEP_DEFAULT   = 16'sd1280;
    localparam logic [15:0]        PRESSURE_FLOOR = 16'd655;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         touch_id;
        logic [15:0]        x_pos;
        logic [15:0]        y_pos;
        logic [15:0]        z_pos;
        logic [3:0]         row_select;
        logic signed [15:0] row_step;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_touch_id;
        logic [1:0]         event_kind;
        logic signed [15:0] note;
        logic signed [7:0]  note_whole;
        logic [14:0]        x_semitones;
        logic [15:0]        y_in_row;
        logic [15:0]        pressure;
    } out_item_t;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] fp;
        logic [6:0]  rows;
        logic [6:0]  semi;
        logic [14:0] base;
    } cfg_t;

endpackage

@@ rtl/tgnm_div_pipe.sv @@
// ============================================================================
// tgnm_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. Stages advance only when enable is high.
// ============================================================================
module tgnm_div_pipe #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int TW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag_in,
    output logic [NW-1:0] quo,
    output logic [TW-1:0] tag_out
);

    logic [NW-1:0] q_reg   [NW+1];
    logic [DW:0]   r_reg   [NW+1];
    logic [DW-1:0] d_reg   [NW+1];
    logic [TW-1:0] t_reg   [NW+1];

    assign q_reg[0] = num;
    assign r_reg[0] = '0;
    assign d_reg[0] = den;
    assign t_reg[0] = tag_in;

    for (genvar s = 0; s < NW; s++) begin : g_st
        logic [DW+1:0] trial;
        logic [DW:0]   rq_next;
        logic [NW-1:0] qq_next;
        logic [NW-1:0] qs_reg;
        logic [DW:0]   rs_reg;
        logic [DW-1:0] ds_reg;
        logic [TW-1:0] ts_reg;

        always_comb
        begin
            trial   = {r_reg[s], q_reg[s][NW-1]};
            if (trial >= {2'b00, d_reg[s]})
            begin
                rq_next = (DW+1)'(trial - {2'b00, d_reg[s]});
                qq_next = {q_reg[s][NW-2:0], 1'b1};
            end
            else
            begin
                rq_next = trial[DW:0];
                qq_next = {q_reg[s][NW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qs_reg <= qq_next;
                rs_reg <= rq_next;
                ds_reg <= d_reg[s];
                ts_reg <= t_reg[s];
            end
        end

        assign q_reg[s+1] = qs_reg;
        assign r_reg[s+1] = rs_reg;
        assign d_reg[s+1] = ds_reg;
        assign t_reg[s+1] = ts_reg;
    end

    assign quo     = q_reg[NW];
    assign tag_out = t_reg[NW];

endmodule

@@ rtl/tgnm_row_sum.sv @@
// ============================================================================
// tgnm_row_sum
// Row step table and prefix sums. A write replaces one step and adds the
// change onto every prefix above that row in the same cycle.
// ============================================================================
module tgnm_row_sum #(
    parameter int MAX_ROWS = tgnm_pkg::MAX_ROWS_DEF,
    parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [3:0]          wr_row,
    input  logic signed [15:0]  wr_step,
    input  logic [RW-1:0]       rd_row,
    output logic signed [21:0]  rd_sum
);

    logic signed [15:0] step_reg [MAX_ROWS];
    logic signed [21:0] pre_reg  [MAX_ROWS];
    logic               wr_hit;
    logic signed [16:0] delta;

    always_comb
    begin
        wr_hit = wr_en && (int'(wr_row) < MAX_ROWS);
        delta  = 17'(wr_step) - 17'(step_reg[RW'(wr_row)]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                step_reg[i] <= (i == 0) ? 16'sd0 : tgnm_pkg::STEP_DEFAULT;
                pre_reg[i]  <= 22'((i > 0) ? (i - 1) * int'(tgnm_pkg::STEP_DEFAULT) : 0);
            end
        end
        else if (wr_hit)
        begin
            step_reg[RW'(wr_row)] <= wr_step;
            // shift the prefix of every row above the written one
            for (int i = 1; i < MAX_ROWS; i++)
            begin
                if (i > int'(wr_row))
                    pre_reg[i] <= pre_reg[i] + 22'(delta);
            end
        end
    end

    assign rd_sum = pre_reg[rd_row];

endmodule

@@ rtl/touch_grid_to_note_mapper_unit.sv @@
// ============================================================================
// touch_grid_to_note_mapper_unit
// Maps touch events onto a row grid and returns note, position and pressure.
// ============================================================================
// Usage: present items on in_data with in_valid; a transaction happens when
// in_valid and in_ready are high. Touch events (on, continue, off) give one
// result on out_data; a row step write gives none. Configuration registers are
// written through cfg_we/cfg_index/cfg_data while no transaction is in flight.
// Each input transaction passes one input register, 38 stages of the pipelined
// dividers that work x, y and pressure in parallel, and the output register on
// its way to out_data. Throughput is one item per cycle while the receiver does
// not stall. Row step writes travel down the same pipeline and update the step
// table in order with the touches around them.
// The whole pipeline advances together: when the receiver stalls with a result
// waiting, every stage holds and in_ready drops, so nothing is lost.
// Reset clears all valid bits, loads register defaults and the default steps.
// ============================================================================
module touch_grid_to_note_mapper_unit #(
    parameter int MAX_ROWS = tgnm_pkg::MAX_ROWS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tgnm_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tgnm_pkg::out_item_t   out_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NW  = 38;
    localparam int LAT = NW + 2;

    tgnm_pkg::cfg_t cfg_reg;
    logic [15:0] pw_reg, ph_reg, fp_reg;
    logic [4:0]  rc_reg;
    logic [6:0]  sa_reg;
    logic [14:0] bn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg <= 16'd65535;
            ph_reg <= 16'd65535;
            fp_reg <= 16'd4095;
            rc_reg <= 5'd10;
            sa_reg <= 7'd18;
            bn_reg <= 15'd8192;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tgnm_pkg::REG_PANEL_WIDTH:  pw_reg <= cfg_data;
                tgnm_pkg::REG_PANEL_HEIGHT: ph_reg <= cfg_data;
                tgnm_pkg::REG_FULL_PRESS:   fp_reg <= cfg_data;
                tgnm_pkg::REG_ROW_COUNT:    rc_reg <= cfg_data[4:0];
                tgnm_pkg::REG_SEMI_ACROSS:  sa_reg <= cfg_data[6:0];
                tgnm_pkg::REG_BASE_NOTE:    bn_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg_reg.w    = (pw_reg == '0) ? 16'd1 : pw_reg;
        cfg_reg.h    = (ph_reg == '0) ? 16'd1 : ph_reg;
        cfg_reg.fp   = (fp_reg == '0) ? 16'd1 : fp_reg;
        cfg_reg.rows = (rc_reg == '0) ? 7'd1 :
                       ({2'b0, rc_reg} > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : {2'b0, rc_reg};
        cfg_reg.semi = sa_reg;
        cfg_reg.base = bn_reg;
    end

    logic en;
    logic [LAT-1:0] v_reg;
    logic [NW:0]    wv_reg;
    assign en        = !v_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[LAT-1];

    logic acc, touch, wr_in;
    assign acc   = in_valid && in_ready;
    assign touch = acc && (in_data.command != tgnm_pkg::CMD_WRITE);
    assign wr_in = acc && (in_data.command == tgnm_pkg::CMD_WRITE);

    // Stage 0: clamp positions and build multiplications.
    logic [15:0] xc, yc, inv;
    always_comb
    begin
        xc  = (in_data.x_pos > cfg_reg.w) ? cfg_reg.w : in_data.x_pos;
        yc  = (in_data.y_pos > cfg_reg.h) ? cfg_reg.h : in_data.y_pos;
        inv = cfg_reg.h - yc;
    end

    logic [7:0]  s0_id_reg;
    logic [1:0]  s0_cmd_reg;
    logic [3:0]  s0_sel_reg;
    logic [15:0] s0_step_reg;
    logic [22:0] s0_xm_reg;
    logic [22:0] s0_ym_reg;
    logic [15:0] s0_z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_id_reg   <= in_data.touch_id;
            s0_cmd_reg  <= in_data.command;
            s0_sel_reg  <= in_data.row_select;
            s0_step_reg <= in_data.row_step;
            s0_xm_reg   <= 23'(xc) * 23'(cfg_reg.semi);
            s0_ym_reg   <= 23'(inv) * 23'(cfg_reg.rows);
            s0_z_reg    <= in_data.z_pos;
        end
    end

    // Touch and row write valid bits travel separately beside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            wv_reg <= '0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[LAT-2:0], touch};
            wv_reg <= {wv_reg[NW-1:0], wr_in};
        end
    end

    // Dividers: x scaled by 256, y with 16 fraction bits, pressure by 65536.
    logic [NW-1:0] xq, yq, pq;
    logic [7:0]    id_q;
    logic [19:0]   wr_q;
    logic [1:0]    cmd_q;

    tgnm_div_pipe #(.NW(NW), .DW(16), .TW(8)) u_div_x (
        .clk(clk), .en(en),
        .num(NW'({s0_xm_reg, 8'd0})), .den(cfg_reg.w),
        .tag_in(s0_id_reg), .quo(xq), .tag_out(id_q)
    );
    tgnm_div_pipe #(.NW(NW), .DW(16), .TW(20)) u_div_y (
        .clk(clk), .en(en),
        .num(NW'({s0_ym_reg, 16'd0})), .den(cfg_reg.h),
        .tag_in({s0_sel_reg, s0_step_reg}), .quo(yq), .tag_out(wr_q)
    );
    tgnm_div_pipe #(.NW(NW), .DW(16), .TW(2)) u_div_p (
        .clk(clk), .en(en),
        .num(NW'({s0_z_reg, 16'd0})), .den(cfg_reg.fp),
        .tag_in(s0_cmd_reg), .quo(pq), .tag_out(cmd_q)
    );

    // Row index: integer part of y quotient, clamped to last row.
    logic [21:0] row_raw;
    logic [RW-1:0] row;
    logic        row_clamp;
    logic [15:0] frac;
    always_comb
    begin
        row_raw   = yq[37:16];
        row_clamp = row_raw >= 22'(cfg_reg.rows);
        row       = row_clamp ? RW'(cfg_reg.rows - 7'd1) : RW'(row_raw);
        frac      = row_clamp ? 16'hFFFF : yq[15:0];
    end

    // Apply a row write as it leaves the last divider stage, in order with touches.
    logic signed [21:0] rsum;
    tgnm_row_sum #(.MAX_ROWS(MAX_ROWS), .RW(RW)) u_rows (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wv_reg[NW] && en),
        .wr_row(wr_q[19:16]), .wr_step($signed(wr_q[15:0])),
        .rd_row(row), .rd_sum(rsum)
    );

    // Final stage: sum, saturate and format.
    logic signed [24:0] nsum;
    logic [15:0]        nb;
    logic [15:0]        pr;
    tgnm_pkg::out_item_t res;
    always_comb
    begin
        nsum = 25'($signed({1'b0, xq[23:0]})) + 25'(rsum) + 25'($signed({1'b0, cfg_reg.base}));
        if (nsum > 25'sd32767)
            nb = 16'hFFFF;
        else if (nsum < -25'sd32768)
            nb = 16'h0000;
        else
            nb = 16'(nsum + 25'sd32768);
        pr = (pq > NW'(65535)) ? 16'hFFFF :
             (pq < NW'(655))   ? tgnm_pkg::PRESSURE_FLOOR : pq[15:0];
        res.out_touch_id = id_q;
        res.event_kind   = cmd_q;
        res.note_whole   = $signed(nb[15:8] ^ 8'h80);
        res.note         = $signed(((cmd_q == tgnm_pkg::CMD_ON) ?
                                    {nb[15:8], 8'h00} : nb) ^ 16'h8000);
        res.x_semitones  = xq[14:0];
        res.y_in_row     = frac;
        res.pressure     = pr;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data <= res;
    end

endmodule
